// ----- design/sbda_pkg.sv -----
// Shared types and constants for the signed binary to decimal ASCII converter.
// This file depends on nothing. The controller and the datapath both use it.
`timescale 1ns / 1ps

package sbda_pkg;

    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [3:0] DIGIT_NINE = 4'd9;
    localparam logic [3:0] DIGIT_FIVE = 4'd5;
    localparam logic [3:0] DIGIT_ADJ  = 4'd3;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SHIFT  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_SIGN   = 5'b01000,
        ST_DIGITS = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
        logic scan;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic last_shift;
        logic negative;
        logic ptr_zero;
        logic out_free;
    } t_status;

endpackage

// ----- design/sbda_ctrl.sv -----
// Controller state machine for the signed binary to decimal ASCII converter.
// It depends on sbda_pkg and drives the datapath through t_cmd / t_status.
`timescale 1ns / 1ps

module sbda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sbda_pkg::t_status i_status,
    output sbda_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    sbda_pkg::t_state r_state;
    sbda_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            sbda_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sbda_pkg::ST_SHIFT;
                end
            end
            sbda_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.last_shift) begin
                    n_state = sbda_pkg::ST_SCAN;
                end
            end
            sbda_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state = i_status.negative ? sbda_pkg::ST_SIGN : sbda_pkg::ST_DIGITS;
            end
            sbda_pkg::ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = sbda_pkg::ST_DIGITS;
                end
            end
            sbda_pkg::ST_DIGITS: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.ptr_zero) begin
                        n_state = sbda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != sbda_pkg::ST_IDLE);

endmodule

// ----- design/sbda_dp.sv -----
// Datapath for the signed binary to decimal ASCII converter: magnitude,
// shift-add-3 BCD register, digit pointer and output register. Uses sbda_pkg.
`timescale 1ns / 1ps

module sbda_dp #(
    parameter int MAX_DIGITS   = 10,
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic signed [NUMBER_WIDTH-1:0] i_number,
    input  logic                           i_stall,
    input  sbda_pkg::t_cmd                 i_cmd,
    output sbda_pkg::t_status              o_status,
    output logic                           o_valid,
    output logic [6:0]                     o_character,
    output logic                           o_last_char
);

    localparam int CW = $clog2(NUMBER_WIDTH + 1);
    localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int BW = 4 * MAX_DIGITS;

    logic [NUMBER_WIDTH-1:0]   r_mag;
    logic                      r_neg;
    logic [MAX_DIGITS-1:0][3:0] r_bcd;
    logic [MAX_DIGITS-1:0][3:0] adj_bcd;
    logic                      r_ovf;
    logic [CW-1:0]             r_cnt;
    logic [PW-1:0]             r_ptr;
    logic [PW-1:0]             lead;
    logic                      r_ovalid;
    logic [6:0]                r_char;
    logic                      r_last;
    logic [NUMBER_WIDTH-1:0]   neg_mag;
    logic                      out_free;

    assign neg_mag  = ~i_number + NUMBER_WIDTH'(1);
    assign out_free = !r_ovalid || !i_stall;

    // Add 3 to every digit of five or more before each doubling.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            adj_bcd[i] = (r_bcd[i] >= sbda_pkg::DIGIT_FIVE) ?
                         r_bcd[i] + sbda_pkg::DIGIT_ADJ : r_bcd[i];
        end
    end

    // Most significant nonzero digit; zero maps to the lowest digit.
    always_comb begin
        lead = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                lead = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= i_number[NUMBER_WIDTH-1] ? neg_mag : i_number;
            r_neg <= i_number[NUMBER_WIDTH-1];
            r_bcd <= '0;
            r_ovf <= 1'b0;
            r_cnt <= CW'(NUMBER_WIDTH);
        end else if (i_cmd.shift) begin
            r_bcd <= BW'({adj_bcd, r_mag[NUMBER_WIDTH-1]});
            r_mag <= r_mag << 1;
            // A bit leaving the top digit means the value needs more digits.
            r_ovf <= r_ovf | adj_bcd[MAX_DIGITS-1][3];
            r_cnt <= r_cnt - CW'(1);
        end else if (i_cmd.scan) begin
            if (r_ovf) begin
                r_bcd <= {MAX_DIGITS{sbda_pkg::DIGIT_NINE}};
                r_ptr <= PW'(MAX_DIGITS - 1);
            end else begin
                r_ptr <= lead;
            end
        end else if (i_cmd.emit_digit) begin
            r_ptr <= r_ptr - PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= sbda_pkg::CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= sbda_pkg::CHAR_ZERO + {3'd0, r_bcd[r_ptr]};
            r_last <= (r_ptr == '0);
        end
    end

    assign o_status.last_shift = (r_cnt == CW'(1));
    assign o_status.negative   = r_neg;
    assign o_status.ptr_zero   = (r_ptr == '0);
    assign o_status.out_free   = out_free;

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

// ----- design/signed_binary_to_decimal_ascii.sv -----
// Top level of the signed binary to decimal ASCII converter.
// Instantiates sbda_ctrl and sbda_dp, which share types from sbda_pkg.
//
//   Channel | Handshake         | Payload
//   --------+-------------------+------------------------------
//   input   | i_valid / o_stall | i_number (signed)
//   output  | o_valid / i_stall | o_character, o_last_char
//
// One request runs shift-add-3 conversion over the magnitude bits and a digit
// scan, then emits one character per cycle while the output is not stalled (up
// to MAX_DIGITS + 1 characters). Reset is synchronous and active low; it clears
// the state machine and the output valid. A stall on the output holds the
// current character and pauses emission; a new request is taken while the last
// character still waits.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii #(
    parameter int MAX_DIGITS   = 10,
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [NUMBER_WIDTH-1:0] i_number,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [6:0]                     o_character,
    output logic                           o_last_char
);

    sbda_pkg::t_cmd    cmd;
    sbda_pkg::t_status status;
    logic              busy;

    sbda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sbda_dp #(
        .MAX_DIGITS   (MAX_DIGITS),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_number    (i_number),
        .i_stall     (i_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    assign o_stall = busy;

endmodule
